// ===== rtl/rmsa_pkg.sv =====
package rmsa_pkg;

  localparam int unsigned SampleBits   = 16;
  localparam int unsigned CountBits    = 16;
  localparam int unsigned SumBitsFull  = 2 * SampleBits - 1 + CountBits;
  localparam int unsigned SumBits      = (SumBitsFull > 63) ? 63 : SumBitsFull;
  localparam int unsigned SqBits       = 2 * SampleBits - 1;
  localparam int unsigned RootBits     = (SumBits + 1) / 2;
  localparam int unsigned RadBits      = 2 * RootBits;
  localparam int unsigned OutValueBits = 16;
  localparam int unsigned OutCountBits = 16;
  // power of two, pointers wrap on their own
  localparam int unsigned QueueDepth   = 4;
  localparam int unsigned QueuePtrBits = $clog2(QueueDepth);
  localparam int unsigned IterBits     = $clog2(SumBits);

  typedef struct packed {
    logic [SumBits-1:0]   sum;
    logic [CountBits-1:0] count;
  } rmsa_snap_t;

  // front to queue: one finished group
  typedef struct packed {
    logic       valid;
    rmsa_snap_t snap;
  } rmsa_push_t;

  // queue to back: oldest waiting group
  typedef struct packed {
    logic       valid;
    rmsa_snap_t snap;
  } rmsa_head_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkDiv,
    BkSqrt,
    BkDone
  } rmsa_back_state_e;

endpackage

// ===== rtl/rmsa_front.sv =====
module rmsa_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [rmsa_pkg::SampleBits-1:0] sample_i,
  input  logic                                sample_absent_i,
  input  logic                                group_end_i,
  input  logic                                queue_full_i,
  output rmsa_pkg::rmsa_push_t                push_o
);
  import rmsa_pkg::*;

  logic                    s1_valid_q, s1_valid_d;
  logic                    s1_present_q;
  logic                    s1_last_q;
  logic [SqBits-1:0]       s1_sq_q;
  logic [SampleBits-1:0]   raw;
  logic [SampleBits-1:0]   mag;
  logic [2*SampleBits-1:0] sq_full;
  logic [SumBits-1:0]      sum_q, sum_d, sum_acc, sum_new;
  logic [SumBits:0]        sum_wide;
  logic [CountBits-1:0]    cnt_q, cnt_d, cnt_acc, cnt_new;
  logic                    advance;
  logic                    go;

  // only a group end facing a full queue holds the pipe
  assign in_stall_o = s1_valid_q && s1_last_q && queue_full_i;
  assign advance    = !in_stall_o;
  assign go         = s1_valid_q && advance;

  assign raw     = sample_i;
  assign mag     = raw[SampleBits-1] ? (~raw + 1'b1) : raw;
  assign sq_full = (2*SampleBits)'(mag) * (2*SampleBits)'(mag);

  assign sum_wide = {1'b0, sum_q} + (SumBits+1)'(s1_sq_q);
  assign sum_acc  = sum_wide[SumBits] ? '1 : sum_wide[SumBits-1:0];
  assign cnt_acc  = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
  assign sum_new  = s1_present_q ? sum_acc : sum_q;
  assign cnt_new  = s1_present_q ? cnt_acc : cnt_q;

  assign push_o.valid      = go && s1_last_q;
  assign push_o.snap.sum   = sum_new;
  assign push_o.snap.count = cnt_new;

  assign s1_valid_d = advance ? in_valid_i : s1_valid_q;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (go) begin
      if (s1_last_q) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_new;
        cnt_d = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      sum_q      <= '0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      sum_q      <= sum_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_sq_q      <= sq_full[SqBits-1:0];
      s1_present_q <= !sample_absent_i;
      s1_last_q    <= group_end_i;
    end
  end

endmodule

// ===== rtl/rmsa_queue.sv =====
module rmsa_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rmsa_pkg::rmsa_push_t push_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output rmsa_pkg::rmsa_head_t head_o
);
  import rmsa_pkg::*;

  rmsa_snap_t              mem_q [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueuePtrBits:0]   fill_q, fill_d;
  logic                    do_push;
  logic                    do_pop;

  assign full_o      = (fill_q == (QueuePtrBits+1)'(QueueDepth));
  assign head_o.valid = (fill_q != '0);
  assign head_o.snap  = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    case ({do_push, do_pop})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.snap;
    end
  end

endmodule

// ===== rtl/rmsa_back.sv =====
module rmsa_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rmsa_pkg::rmsa_head_t              head_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rmsa_pkg::OutValueBits-1:0] rms_value_o,
  output logic                              result_missing_o,
  output logic [rmsa_pkg::OutCountBits-1:0] sample_count_o
);
  import rmsa_pkg::*;

  rmsa_back_state_e        state_q, state_d;
  logic [IterBits-1:0]     iter_q;
  logic [SumBits-1:0]      dvd_q;
  logic [CountBits-1:0]    div_q;
  logic [CountBits-1:0]    rem_q;
  logic [RadBits-1:0]      rad_q;
  logic [RootBits-1:0]     root_q;
  logic [RootBits:0]       srem_q;
  logic                    miss_q;
  logic                    out_valid_q;
  logic [OutValueBits-1:0] value_q;
  logic                    missing_q;
  logic [OutCountBits-1:0] count_q;
  logic                    load_out;
  logic                    iter_last;

  // restoring divide, one quotient bit per cycle
  logic [CountBits:0]      dshift, ddiff;
  logic                    dge;
  logic [SumBits-1:0]      quo_next;
  // digit-by-digit square root, two radicand bits per cycle
  logic [RootBits+2:0]     sshift, strial, sdiff;
  logic                    sge;

  assign iter_last = (iter_q == '0);

  assign dshift   = {rem_q, dvd_q[SumBits-1]};
  assign dge      = (dshift >= {1'b0, div_q});
  assign ddiff    = dshift - {1'b0, div_q};
  assign quo_next = {dvd_q[SumBits-2:0], dge};

  assign sshift = {srem_q, rad_q[RadBits-1 -: 2]};
  assign strial = {1'b0, root_q, 2'b01};
  assign sge    = (sshift >= strial);
  assign sdiff  = sshift - strial;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: begin
        if (head_i.valid) begin
          state_d = (head_i.snap.count == '0) ? BkDone : BkDiv;
        end
      end
      BkDiv: begin
        if (iter_last) state_d = BkSqrt;
      end
      BkSqrt: begin
        if (iter_last) state_d = BkDone;
      end
      BkDone: begin
        if (load_out) state_d = BkIdle;
      end
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    pop_o    = (state_q == BkIdle) && head_i.valid;
    load_out = (state_q == BkDone) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BkIdle: begin
        if (pop_o) begin
          dvd_q  <= head_i.snap.sum;
          div_q  <= head_i.snap.count;
          rem_q  <= '0;
          root_q <= '0;
          miss_q <= (head_i.snap.count == '0);
          iter_q <= IterBits'(SumBits - 1);
        end
      end
      BkDiv: begin
        rem_q <= dge ? ddiff[CountBits-1:0] : dshift[CountBits-1:0];
        dvd_q <= quo_next;
        if (iter_last) begin
          rad_q  <= RadBits'(quo_next);
          root_q <= '0;
          srem_q <= '0;
          iter_q <= IterBits'(RootBits - 1);
        end else begin
          iter_q <= iter_q - 1'b1;
        end
      end
      BkSqrt: begin
        srem_q <= sge ? sdiff[RootBits:0] : sshift[RootBits:0];
        root_q <= {root_q[RootBits-2:0], sge};
        rad_q  <= {rad_q[RadBits-3:0], 2'b00};
        iter_q <= iter_q - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      value_q   <= OutValueBits'(root_q);
      missing_q <= miss_q;
      count_q   <= OutCountBits'(div_q);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign rms_value_o      = value_q;
  assign result_missing_o = missing_q;
  assign sample_count_o   = count_q;

endmodule

// ===== rtl/rms_accumulator.sv =====
// rms_accumulator: root mean square over groups of signed samples.
// Input channel (in_valid_i / in_stall_o) carries one sample per request with
// an absent flag and a group-end flag. Present samples are squared and summed
// with saturation; the group end hands the sum and count to a four-entry
// queue and clears the accumulator.
// Output channel (out_valid_o / out_stall_i) carries one request per group:
// floor(sqrt(sum / count)), the count, and a missing flag for empty groups.
// Throughput: one sample per cycle; the front only stalls when a group end
// meets a full queue. In the back end each group takes a load, 47 divide
// steps, 24 square-root steps and an output load (an empty group skips the
// divide and root steps) in the bit-serial divider and root unit; up to four
// group ends can be buffered. A group's result passes the queue, back end
// and output register, and waits while earlier groups are still queued.
// Reset clears the accumulator, the queue and the output valid at once.
// A stalled output holds its result; the back end waits, the queue fills,
// and then group ends stall the input.
module rms_accumulator (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [rmsa_pkg::SampleBits-1:0] sample_i,
  input  logic                                   sample_absent_i,
  input  logic                                   group_end_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [rmsa_pkg::OutValueBits-1:0]      rms_value_o,
  output logic                                   result_missing_o,
  output logic [rmsa_pkg::OutCountBits-1:0]      sample_count_o
);
  import rmsa_pkg::*;

  rmsa_push_t push;
  rmsa_head_t head;
  logic       queue_full;
  logic       pop;

  rmsa_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_i        (sample_i),
    .sample_absent_i (sample_absent_i),
    .group_end_i     (group_end_i),
    .queue_full_i    (queue_full),
    .push_o          (push)
  );

  rmsa_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (queue_full),
    .pop_i  (pop),
    .head_o (head)
  );

  rmsa_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .rms_value_o      (rms_value_o),
    .result_missing_o (result_missing_o),
    .sample_count_o   (sample_count_o)
  );

endmodule
